// File: rtl/core/tdw_pkg.sv
// Shared constants and the token type of the terminal display width block.
// Used by the front classifier, the token queue and the back decoder.
package tdw_pkg;

	localparam int COUNT_BITS = 16;

	localparam logic [7:0] ESC_BYTE = 8'h1b;
	localparam logic [7:0] CSI_BYTE = 8'h5b;
	localparam logic [7:0] FINAL_LO = 8'h40;
	localparam logic [7:0] FINAL_HI = 8'h7e;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One beat from front to back: an optional ESC passed through ahead of
	// an optional byte, and the end-of-string mark.
	typedef struct packed {
		logic       esc_first;
		logic       byte_valid;
		logic [7:0] data;
		logic       last;
	} tdw_token_t;

endpackage

// File: rtl/core/terminal_display_width.sv
// Top level of the terminal display width block.
// Depends on tdw_pkg, tdw_front, tdw_queue and tdw_back.
//
// Usage:
//   Input queue: drive text_byte and last_byte with push high; a beat is
//   taken at a clock edge where push is high and full is low. Set last_byte
//   on the final byte of each string.
//   Result slot: while empty is low, column_count and count_saturated hold
//   the result of the oldest finished string; pop it with pop high.
// Throughput: one byte per cycle while full is low. The per-byte decode
//   (two chained decoder steps, a wide range check and one saturating add)
//   is combinational. Result: the back stage registers a string's result
//   in the output slot when it takes the end-of-string token from the queue.
// Stall: the back stage holds an end-of-string token while an earlier result
//   still waits; the four-entry token queue keeps absorbing bytes until it
//   fills, then full rises. Later bytes wait in the queue during the stall.
// Reset: arst_n low clears the escape and control-sequence flags, the held
//   byte count, the counter and the result slot. No warm-up is needed.
module terminal_display_width
	import tdw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] column_count,
	output logic        count_saturated
);

	logic       accept;
	logic       tok_push;
	tdw_token_t front_tok;
	tdw_token_t head_tok;
	logic       q_empty;
	logic       tok_take;

	// the front keeps only two flag bits, so it stalls only on a full queue
	assign accept = push && !full;

	tdw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.tok_push  (tok_push),
		.tok       (front_tok)
	);

	// dropped control-sequence bytes enter the queue only as an end-of-string mark
	tdw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tok_push),
		.push_tok (front_tok),
		.full     (full),
		.pop      (tok_take),
		.empty    (q_empty),
		.head_tok (head_tok)
	);

	tdw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.tok_valid       (!q_empty),
		.tok             (head_tok),
		.tok_take        (tok_take),
		.empty           (empty),
		.pop             (pop),
		.column_count    (column_count),
		.count_saturated (count_saturated)
	);

endmodule

// File: rtl/core/tdw_front.sv
// Front classifier: strips ESC-[ control sequences and emits tokens.
// Depends on tdw_pkg for the byte codes and the token type.
module tdw_front
	import tdw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	output logic       tok_push,
	output tdw_token_t tok
);

	logic esc_q, csi_q;
	logic esc_d, csi_d;

	always_comb begin
		esc_d          = esc_q;
		csi_d          = csi_q;
		tok.esc_first  = 1'b0;
		tok.byte_valid = 1'b0;
		tok.data       = text_byte;
		tok.last       = last_byte;
		if (csi_q) begin
			// drop everything up to and including the final byte
			if (text_byte >= FINAL_LO && text_byte <= FINAL_HI) csi_d = 1'b0;
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (text_byte == CSI_BYTE) begin
				csi_d = 1'b1;
			end else begin
				tok.esc_first = 1'b1;
				if (text_byte == ESC_BYTE && !last_byte) esc_d = 1'b1;
				else tok.byte_valid = 1'b1;
			end
		end else begin
			if (text_byte == ESC_BYTE && !last_byte) esc_d = 1'b1;
			else tok.byte_valid = 1'b1;
		end
		if (last_byte) begin
			esc_d = 1'b0;
			csi_d = 1'b0;
		end
	end

	assign tok_push = accept && (tok.esc_first || tok.byte_valid || tok.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			csi_q <= 1'b0;
		end else if (accept) begin
			esc_q <= esc_d;
			csi_q <= csi_d;
		end
	end

endmodule

// File: rtl/core/tdw_queue.sv
// Short token queue that decouples the front classifier from the back decoder.
// Depends on tdw_pkg for the token type and queue depth.
module tdw_queue
	import tdw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tdw_token_t push_tok,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output tdw_token_t head_tok
);

	tdw_token_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	logic do_push, do_pop;

	assign full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
				: wr_ptr_q + QUEUE_PTR_W'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
				: rd_ptr_q + QUEUE_PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + QUEUE_CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - QUEUE_CNT_W'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("token queue count out of range");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full)
		else $error("token queue lost an entry while full");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && !pop |=> !empty)
		else $error("token queue empty after a push");

endmodule

// File: rtl/core/tdw_back.sv
// Back decoder: UTF-8 lead tracking, wide range check, saturating column count.
// Depends on tdw_pkg for the token type, ESC code and counter width.
module tdw_back
	import tdw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  tdw_token_t  tok,
	output logic        tok_take,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] column_count,
	output logic        count_saturated
);

	localparam int SHOW_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	typedef struct packed {
		logic [1:0] cnt;
		logic [1:0] need;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} pend_t;

	typedef struct packed {
		pend_t      st;
		logic [1:0] cols;
	} feed_t;

	function automatic logic [1:0] lead_need(logic [7:0] c);
		if (c[7:5] == 3'b110) return 2'd1;
		if (c[7:4] == 4'b1110) return 2'd2;
		if (c[7:3] == 5'b11110) return 2'd3;
		return 2'd0;
	endfunction

	function automatic logic is_wide(logic [20:0] cp);
		return (cp >= 21'h1100 && cp <= 21'h115F) ||
			(cp >= 21'h2E80 && cp <= 21'hA4CF && cp != 21'h303F) ||
			(cp >= 21'hAC00 && cp <= 21'hD7A3) ||
			(cp >= 21'hF900 && cp <= 21'hFAFF) ||
			(cp >= 21'hFE10 && cp <= 21'hFE19) ||
			(cp >= 21'hFE30 && cp <= 21'hFE6F) ||
			(cp >= 21'hFF00 && cp <= 21'hFF60) ||
			(cp >= 21'hFFE0 && cp <= 21'hFFE6) ||
			(cp >= 21'h20000 && cp <= 21'h3FFFD);
	endfunction

	// One byte into the decoder: count ASCII, hold a lead, drop a stray byte, append or complete.
	function automatic feed_t feed(pend_t st, logic [7:0] c);
		feed_t       r;
		logic [20:0] cp;
		r      = '{st: st, cols: 2'd0};
		cp     = '0;
		if (st.cnt == 2'd0) begin
			if (!c[7]) begin
				r.cols = 2'd1;
			end else if (lead_need(c) != 2'd0) begin
				r.st.b0   = c;
				r.st.cnt  = 2'd1;
				r.st.need = lead_need(c);
			end
		end else if (st.cnt >= st.need) begin
			unique case (st.need)
				2'd1:    cp = {10'd0, st.b0[4:0], c[5:0]};
				2'd2:    cp = {5'd0, st.b0[3:0], st.b1[5:0], c[5:0]};
				2'd3:    cp = {st.b0[2:0], st.b1[5:0], st.b2[5:0], c[5:0]};
				default: cp = '0;
			endcase
			r.cols    = is_wide(cp) ? 2'd2 : 2'd1;
			r.st.cnt  = 2'd0;
			r.st.need = 2'd0;
		end else begin
			if (st.cnt == 2'd1) r.st.b1 = c;
			else r.st.b2 = c;
			r.st.cnt = st.cnt + 2'd1;
		end
		return r;
	endfunction

	pend_t                 pend_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [15:0]           out_count_q;
	logic                  out_sat_q;

	feed_t                 f1, f2;
	pend_t                 s1, s2;
	logic [1:0]            c1, c2, cf;
	logic [2:0]            inc;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] total_d;
	logic                  ovf_d;
	logic [SHOW_W-1:0]     wide_total;
	logic [15:0]           shown;

	always_comb begin
		f1 = feed(pend_q, ESC_BYTE);
		s1 = tok.esc_first ? f1.st : pend_q;
		c1 = tok.esc_first ? f1.cols : 2'd0;
		f2 = feed(s1, tok.data);
		s2 = tok.byte_valid ? f2.st : s1;
		c2 = tok.byte_valid ? f2.cols : 2'd0;

		// end of string: drop a partial lead, decode the held bytes again
		cf = 2'd0;
		if (tok.last) begin
			if (s2.cnt == 2'd2) begin
				cf = {1'b0, !s2.b1[7]};
			end else if (s2.cnt == 2'd3) begin
				if (!s2.b1[7]) cf = 2'd1 + {1'b0, !s2.b2[7]};
				else if (lead_need(s2.b1) == 2'd1) cf = 2'd1;
				else cf = {1'b0, !s2.b2[7]};
			end
		end

		inc     = {1'b0, c1} + {1'b0, c2} + {1'b0, cf};
		sum     = {1'b0, total_q} + (COUNT_BITS + 1)'(inc);
		total_d = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
		ovf_d   = ovf_q | sum[COUNT_BITS];

		wide_total = SHOW_W'(total_d);
		shown      = (wide_total > SHOW_W'(17'h0FFFF)) ? 16'hFFFF : wide_total[15:0];
	end

	// hold a result-bearing token while the output slot is occupied and not being popped
	assign tok_take = tok_valid && (!tok.last || !out_valid_q || pop);
	assign empty    = !out_valid_q;

	assign column_count    = out_count_q;
	assign count_saturated = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_take) begin
				if (tok.last) begin
					pend_q.cnt  <= 2'd0;
					pend_q.need <= 2'd0;
					total_q     <= '0;
					ovf_q       <= 1'b0;
				end else begin
					pend_q  <= s2;
					total_q <= total_d;
					ovf_q   <= ovf_d;
				end
			end
			if (tok_take && tok.last) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take && tok.last) begin
			out_count_q <= shown;
			out_sat_q   <= ovf_d;
		end
	end

	a_pend_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q.cnt != 2'd0 |-> (pend_q.need != 2'd0 && pend_q.cnt <= pend_q.need))
		else $error("held byte count exceeds lead length");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && tok.last |=> (total_q == '0 && !ovf_q && pend_q.cnt == 2'd0 && !empty))
		else $error("string state not cleared after result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_count_q) && $stable(out_sat_q))
		else $error("waiting result changed before pop");

endmodule
